### hdl/dwpi_pkg.sv
`default_nettype none

package dwpi_pkg;

    // build defaults for the top level parameters
    localparam int unsigned PI_DIVISOR_DEFAULT  = 100;
    localparam bit          CLOSED_LOOP_DEFAULT = 1'b1;

    // configuration port
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 15;

    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_SPEED    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PROP_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_INTEG_GAIN   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUT_LIMIT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEADZONE     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_FILTER_SHIFT = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_REVERSE_MASK = 3'd6;

    // register reset values
    localparam logic [14:0] MAX_SPEED_RST    = 15'd0;
    localparam logic [14:0] PROP_GAIN_RST    = 15'd0;
    localparam logic [14:0] INTEG_GAIN_RST   = 15'd0;
    localparam logic [14:0] OUT_LIMIT_RST    = 15'd1000;
    localparam logic [14:0] DEADZONE_RST     = 15'd0;
    localparam logic [3:0]  FILTER_SHIFT_RST = 4'd2;
    localparam logic [1:0]  REVERSE_MASK_RST = 2'd0;

    // operation codes
    localparam logic OP_TICK = 1'b0;
    localparam logic OP_STOP = 1'b1;

    typedef struct packed {
        logic               operation;
        logic signed [15:0] target_left;
        logic signed [15:0] target_right;
        logic signed [15:0] encoder_left;
        logic signed [15:0] encoder_right;
    } tick_t;

    typedef struct packed {
        logic signed [15:0] drive_left;
        logic signed [15:0] drive_right;
        logic signed [15:0] speed_left;
        logic signed [15:0] speed_right;
        logic signed [15:0] pi_out_left;
        logic signed [15:0] pi_out_right;
    } result_t;

endpackage

`default_nettype wire

### hdl/dual_wheel_incremental_pi_speed_loop.sv
// dual wheel speed loop: one request carries targets and raw encoder speeds
// for the left and right wheel and yields one result with drive, filtered
// speed and PI output for both wheels
//
// channels: tick_valid/tick_ready/tick in, result_valid/result_ready/result
// out, cfg_valid/cfg_ready/cfg_index/cfg_data for register writes (always
// ready; write only while no request is in flight)
//
// six register stages: input, error, gain products, magnitude, reciprocal
// partial products, result; one request can be taken every cycle while the
// receiver keeps taking results
// the filter and error state lives in the error stage and the accumulator
// in the result stage, so each stage's recurrence closes within that stage
//
// division by PI_DIVISOR is a multiply by an exact fixed point reciprocal,
// split into two 17 bit halves over one stage
//
// reset clears the loop state, the pipeline and loads register defaults
// when the receiver stalls, stages fill up behind the held result and bubbles
// collapse; tick_ready drops only when every stage holds a request
`default_nettype none

module dual_wheel_incremental_pi_speed_loop #(
    parameter int unsigned PI_DIVISOR  = dwpi_pkg::PI_DIVISOR_DEFAULT,
    parameter bit          CLOSED_LOOP = dwpi_pkg::CLOSED_LOOP_DEFAULT
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             tick_valid,
    output logic                                  tick_ready,
    input  wire dwpi_pkg::tick_t                  tick,
    output logic                                  result_valid,
    input  wire logic                             result_ready,
    output dwpi_pkg::result_t                     result,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [dwpi_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [dwpi_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // exact reciprocal: floor(n / d) == (n * recip) >> shift for n < 2^MagW
    localparam int unsigned MagW       = 33;
    localparam int unsigned HalfW      = 17;
    localparam int unsigned PartW      = MagW + HalfW;
    localparam int unsigned FullW      = PartW + HalfW;
    localparam int unsigned DivLog     = $clog2(PI_DIVISOR);
    localparam int unsigned RecipShift = MagW + DivLog;
    localparam logic [63:0] RecipFull  =
        ((64'd1 << RecipShift) + 64'(PI_DIVISOR) - 64'd1) / 64'(PI_DIVISOR);
    localparam logic [HalfW-1:0] RecipHi = RecipFull[2*HalfW-1:HalfW];
    localparam logic [HalfW-1:0] RecipLo = RecipFull[HalfW-1:0];
    localparam int unsigned Stages     = 6;

    // configuration registers
    logic [14:0] max_speed_reg;
    logic [14:0] prop_gain_reg;
    logic [14:0] integ_gain_reg;
    logic [14:0] out_limit_reg;
    logic [14:0] deadzone_reg;
    logic [3:0]  filter_shift_reg;
    logic [1:0]  reverse_mask_reg;

    // loop state per wheel
    logic signed [15:0] spd_reg  [2];
    logic signed [16:0] prev_reg [2];
    logic signed [15:0] acc_reg  [2];

    // pipeline occupancy and advance
    logic [Stages-1:0] vld_reg;
    logic [Stages-1:0] adv;

    // stage payloads
    dwpi_pkg::tick_t    tick_reg;
    logic               op1_reg, op2_reg, op3_reg, op4_reg;
    logic signed [15:0] tgt1_reg [2];
    logic signed [15:0] tgt2_reg [2];
    logic signed [15:0] tgt3_reg [2];
    logic signed [15:0] tgt4_reg [2];
    logic signed [15:0] spd1_reg [2];
    logic signed [15:0] spd2_reg [2];
    logic signed [15:0] spd3_reg [2];
    logic signed [15:0] spd4_reg [2];
    logic signed [16:0] err1_reg [2];
    logic signed [17:0] derr1_reg [2];
    logic signed [33:0] pp2_reg [2];
    logic signed [32:0] ip2_reg [2];
    logic [MagW-1:0]    mag3_reg [2];
    logic               neg3_reg [2];
    logic [PartW-1:0]   phi4_reg [2];
    logic [PartW-1:0]   plo4_reg [2];
    logic               neg4_reg [2];
    dwpi_pkg::result_t  result_reg;

    // next values
    logic signed [15:0] tgt_next  [2];
    logic signed [15:0] spd_next  [2];
    logic signed [16:0] err_next  [2];
    logic signed [17:0] derr_next [2];
    logic signed [33:0] pp_next   [2];
    logic signed [32:0] ip_next   [2];
    logic [MagW-1:0]    mag_next  [2];
    logic               neg_next  [2];
    logic [PartW-1:0]   phi_next  [2];
    logic [PartW-1:0]   plo_next  [2];
    logic signed [15:0] acc_next  [2];
    logic signed [15:0] drv_next  [2];
    logic signed [15:0] pi_next   [2];
    dwpi_pkg::result_t  result_next;

    // handshakes
    always_comb
    begin
        adv[Stages-1] = !vld_reg[Stages-1] || result_ready;
        for (int k = Stages - 2; k >= 0; k--)
        begin
            adv[k] = !vld_reg[k] || adv[k+1];
        end
    end

    assign tick_ready   = adv[0];
    assign result_valid = vld_reg[Stages-1];
    assign result       = result_reg;
    assign cfg_ready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                vld_reg[0] <= tick_valid;
            end
            for (int k = 1; k < Stages; k++)
            begin
                if (adv[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_speed_reg    <= dwpi_pkg::MAX_SPEED_RST;
            prop_gain_reg    <= dwpi_pkg::PROP_GAIN_RST;
            integ_gain_reg   <= dwpi_pkg::INTEG_GAIN_RST;
            out_limit_reg    <= dwpi_pkg::OUT_LIMIT_RST;
            deadzone_reg     <= dwpi_pkg::DEADZONE_RST;
            filter_shift_reg <= dwpi_pkg::FILTER_SHIFT_RST;
            reverse_mask_reg <= dwpi_pkg::REVERSE_MASK_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                dwpi_pkg::CFG_MAX_SPEED:    max_speed_reg    <= cfg_data[14:0];
                dwpi_pkg::CFG_PROP_GAIN:    prop_gain_reg    <= cfg_data[14:0];
                dwpi_pkg::CFG_INTEG_GAIN:   integ_gain_reg   <= cfg_data[14:0];
                dwpi_pkg::CFG_OUT_LIMIT:    out_limit_reg    <= cfg_data[14:0];
                dwpi_pkg::CFG_DEADZONE:     deadzone_reg     <= cfg_data[14:0];
                dwpi_pkg::CFG_FILTER_SHIFT: filter_shift_reg <= cfg_data[3:0];
                dwpi_pkg::CFG_REVERSE_MASK: reverse_mask_reg <= cfg_data[1:0];
                default:                    ;
            endcase
        end
    end

    // error stage: target clamp, speed filter, error and its change
    always_comb
    begin
        logic signed [15:0] t_in   [2];
        logic signed [15:0] raw_in [2];
        logic signed [16:0] ms;
        logic signed [16:0] t17;
        logic signed [16:0] diff;
        logic signed [16:0] filt;
        ms        = $signed({2'b00, max_speed_reg});
        t_in[0]   = tick_reg.target_left;
        t_in[1]   = tick_reg.target_right;
        raw_in[0] = tick_reg.encoder_left;
        raw_in[1] = tick_reg.encoder_right;
        for (int w = 0; w < 2; w++)
        begin
            t17 = {t_in[w][15], t_in[w]};
            if (t17 > ms)
            begin
                t17 = ms;
            end
            else if (t17 < -ms)
            begin
                t17 = -ms;
            end
            tgt_next[w] = t17[15:0];

            // floor shift keeps the new speed between old speed and raw
            diff = {raw_in[w][15], raw_in[w]} - {spd_reg[w][15], spd_reg[w]};
            diff = diff >>> filter_shift_reg;
            filt = {spd_reg[w][15], spd_reg[w]} + diff;
            spd_next[w]  = CLOSED_LOOP ? filt[15:0] : tgt_next[w];
            err_next[w]  = t17 - {spd_next[w][15], spd_next[w]};
            derr_next[w] = {err_next[w][16], err_next[w]} - {prev_reg[w][16], prev_reg[w]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < 2; w++)
            begin
                spd_reg[w]  <= '0;
                prev_reg[w] <= '0;
            end
        end
        else if (vld_reg[0] && adv[1])
        begin
            for (int w = 0; w < 2; w++)
            begin
                if (tick_reg.operation == dwpi_pkg::OP_STOP)
                begin
                    spd_reg[w]  <= '0;
                    prev_reg[w] <= '0;
                end
                else
                begin
                    spd_reg[w] <= spd_next[w];
                    if (CLOSED_LOOP)
                    begin
                        prev_reg[w] <= err_next[w];
                    end
                end
            end
        end
    end

    // gain products, magnitude and sign of their sum, reciprocal partial products
    always_comb
    begin
        logic signed [34:0] sum;
        logic signed [34:0] absv;
        for (int w = 0; w < 2; w++)
        begin
            pp_next[w] = $signed({1'b0, prop_gain_reg}) * derr1_reg[w];
            ip_next[w] = $signed({1'b0, integ_gain_reg}) * err1_reg[w];
            sum  = pp2_reg[w] + ip2_reg[w];
            absv = sum[34] ? -sum : sum;
            neg_next[w] = sum[34];
            mag_next[w] = absv[MagW-1:0];
            phi_next[w] = mag3_reg[w] * RecipHi;
            plo_next[w] = mag3_reg[w] * RecipLo;
        end
    end

    // result stage: quotient, accumulator, deadzone lift, reversal
    always_comb
    begin
        logic [FullW-1:0]   full;
        logic [FullW-1:0]   quo;
        logic [15:0]        qs;
        logic signed [17:0] inc;
        logic signed [17:0] asum;
        logic signed [17:0] lim;
        logic signed [15:0] dz;
        logic signed [15:0] v;
        lim = $signed({3'b000, out_limit_reg});
        dz  = $signed({1'b0, deadzone_reg});
        for (int w = 0; w < 2; w++)
        begin
            full = {phi4_reg[w], {HalfW{1'b0}}} + {{HalfW{1'b0}}, plo4_reg[w]};
            quo  = full >> RecipShift;
            // a step this large saturates the accumulator either way
            qs   = (quo > FullW'(16'hFFFF)) ? 16'hFFFF : quo[15:0];
            inc  = neg4_reg[w] ? -$signed({2'b00, qs}) : $signed({2'b00, qs});
            asum = {{2{acc_reg[w][15]}}, acc_reg[w]} + inc;
            if (asum > lim)
            begin
                asum = lim;
            end
            else if (asum < -lim)
            begin
                asum = -lim;
            end
            acc_next[w] = asum[15:0];
            pi_next[w]  = CLOSED_LOOP ? acc_next[w] : tgt4_reg[w];

            v = pi_next[w];
            if (dz != 16'sd0)
            begin
                if (v > 16'sd0 && v < dz)
                begin
                    v = dz;
                end
                else if (v < 16'sd0 && v > -dz)
                begin
                    v = -dz;
                end
            end
            drv_next[w] = reverse_mask_reg[w] ? -v : v;
        end

        if (op4_reg == dwpi_pkg::OP_STOP)
        begin
            result_next = '0;
        end
        else
        begin
            result_next.drive_left   = drv_next[0];
            result_next.drive_right  = drv_next[1];
            result_next.speed_left   = spd4_reg[0];
            result_next.speed_right  = spd4_reg[1];
            result_next.pi_out_left  = pi_next[0];
            result_next.pi_out_right = pi_next[1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < 2; w++)
            begin
                acc_reg[w] <= '0;
            end
        end
        else if (vld_reg[4] && adv[5])
        begin
            for (int w = 0; w < 2; w++)
            begin
                if (op4_reg == dwpi_pkg::OP_STOP)
                begin
                    acc_reg[w] <= '0;
                end
                else if (CLOSED_LOOP)
                begin
                    acc_reg[w] <= acc_next[w];
                end
            end
        end
    end

    // stage payloads, no reset
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            tick_reg <= tick;
        end
        if (adv[1])
        begin
            op1_reg <= tick_reg.operation;
            for (int w = 0; w < 2; w++)
            begin
                tgt1_reg[w]  <= tgt_next[w];
                spd1_reg[w]  <= spd_next[w];
                err1_reg[w]  <= err_next[w];
                derr1_reg[w] <= derr_next[w];
            end
        end
        if (adv[2])
        begin
            op2_reg <= op1_reg;
            for (int w = 0; w < 2; w++)
            begin
                tgt2_reg[w] <= tgt1_reg[w];
                spd2_reg[w] <= spd1_reg[w];
                pp2_reg[w]  <= pp_next[w];
                ip2_reg[w]  <= ip_next[w];
            end
        end
        if (adv[3])
        begin
            op3_reg <= op2_reg;
            for (int w = 0; w < 2; w++)
            begin
                tgt3_reg[w] <= tgt2_reg[w];
                spd3_reg[w] <= spd2_reg[w];
                mag3_reg[w] <= mag_next[w];
                neg3_reg[w] <= neg_next[w];
            end
        end
        if (adv[4])
        begin
            op4_reg <= op3_reg;
            for (int w = 0; w < 2; w++)
            begin
                tgt4_reg[w] <= tgt3_reg[w];
                spd4_reg[w] <= spd3_reg[w];
                phi4_reg[w] <= phi_next[w];
                plo4_reg[w] <= plo_next[w];
                neg4_reg[w] <= neg3_reg[w];
            end
        end
        if (adv[5])
        begin
            result_reg <= result_next;
        end
    end

`ifndef SYNTHESIS
    // stop leaves zero filter and error state behind
    a_stop_clears_filter: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && tick_reg.operation == dwpi_pkg::OP_STOP && adv[1]
        |=> spd_reg[0] == 16'sd0 && spd_reg[1] == 16'sd0
            && prev_reg[0] == 17'sd0 && prev_reg[1] == 17'sd0)
        else $error("stop did not clear filter state");

    // stop reaching the result stage clears both accumulators
    a_stop_clears_acc: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[4] && op4_reg == dwpi_pkg::OP_STOP && adv[5]
        |=> acc_reg[0] == 16'sd0 && acc_reg[1] == 16'sd0 && result_reg == '0)
        else $error("stop did not clear accumulator or result");

    // a request is taken only when the pipe can move it
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        tick_valid && tick_ready |-> !(&vld_reg) || result_ready)
        else $error("request taken into a full pipeline");
`endif

endmodule

`default_nettype wire
